### hw/rtl/numeric_literal_scanner_top_macros.svh
// ------------------------------------------------------------------------
// Numeric literal scanner assertion macros
// Shared concurrent check forms, clocked on clk and held off during reset.
// ------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_SCANNER_TOP_MACROS_SVH
`define NUMERIC_LITERAL_SCANNER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define NLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define NLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/nls_pkg.sv
// ------------------------------------------------------------------------
// Numeric literal scanner package
// Beat types, scan phases and character classes shared by the scanner.
// ------------------------------------------------------------------------
package nls_pkg;

    localparam int unsigned POS_BITS  = 16;
    localparam int unsigned CHAR_BITS = 8;

    localparam logic [CHAR_BITS-1:0] RADIX_RESET = 8'd46;  // '.'
    localparam logic [CHAR_BITS-1:0] CH_PLUS     = 8'd43;  // '+'
    localparam logic [CHAR_BITS-1:0] CH_MINUS    = 8'd45;  // '-'
    localparam logic [CHAR_BITS-1:0] CH_EXP_LO   = 8'd101; // 'e'
    localparam logic [CHAR_BITS-1:0] CH_EXP_UP   = 8'd69;  // 'E'
    localparam logic [CHAR_BITS-1:0] CH_SPACE    = 8'd32;
    localparam logic [CHAR_BITS-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_BITS-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_BITS-1:0] CH_ZERO     = 8'd48;
    localparam logic [CHAR_BITS-1:0] CH_NINE     = 8'd57;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_WS,
        PH_INT,
        PH_FRAC,
        PH_EXPS,
        PH_EXPD1,
        PH_EXPD,
        PH_DONE
    } scan_phase_t;

    typedef struct packed {
        logic [CHAR_BITS-1:0] char_code;
        logic [POS_BITS-1:0]  base_position;
        logic                 last_char;
    } nls_in_t;

    typedef struct packed {
        logic                is_number;
        logic [POS_BITS-1:0] start_pos;
        logic [POS_BITS-1:0] scan_count;
    } nls_out_t;

    function automatic logic is_ws(input logic [CHAR_BITS-1:0] c);
        return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
    endfunction

    function automatic logic is_dig(input logic [CHAR_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_sgn(input logic [CHAR_BITS-1:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // Add a small step to a count, clamping at all ones
    function automatic logic [POS_BITS-1:0] sat_add(
        input logic [POS_BITS-1:0] a,
        input logic [1:0]          n
    );
        logic [POS_BITS:0] s;
        s = {1'b0, a} + {{(POS_BITS-1){1'b0}}, n};
        return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
    endfunction

endpackage

### hw/rtl/numeric_literal_scanner_top.sv
// ------------------------------------------------------------------------
// Numeric literal scanner
// Streams one character per beat and reports, on the last character of a
// string, whether it opens with a decimal literal and where that lies.
// ------------------------------------------------------------------------
//
//  channel   handshake              payload    direction
//  -------   --------------------   --------   ---------
//  cfg       cfg_valid / cfg_ready  cfg_data   in
//  in        in_valid / in_ready    in_data    in
//  out       out_valid / out_ready  out_data   out
//
// One character beat is taken every cycle while in_ready is high; a
// result is in the output register the cycle after its last beat fires.
// in_ready drops only while a result sits in the output register and
// out_ready is low; cfg_ready is always high.
// Reset puts the scanner at the start of a string and the radix at '.'.

module numeric_literal_scanner_top
    import nls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CHAR_BITS-1:0] cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  nls_in_t              in_data,

    output logic                 out_valid,
    input  logic                 out_ready,
    output nls_out_t             out_data
);

`include "numeric_literal_scanner_top_macros.svh"

    logic [CHAR_BITS-1:0] radix_reg;
    scan_phase_t          phase_reg, phase_next;
    logic [POS_BITS-1:0]  start_reg, start_next;
    logic [POS_BITS-1:0]  count_reg, count_next;
    logic                 digit_reg, digit_next;
    logic                 out_valid_reg;
    nls_out_t             out_data_reg;

    logic                 in_fire;
    logic [CHAR_BITS-1:0] c;
    logic                 last;
    logic                 c_ws, c_dig, c_sgn, c_exp, c_radix;
    logic [POS_BITS-1:0]  start_base, count_base;
    logic                 digit_base;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Classify the incoming character
    assign c       = in_data.char_code;
    assign last    = in_data.last_char;
    assign c_ws    = is_ws(c);
    assign c_dig   = is_dig(c);
    assign c_sgn   = is_sgn(c);
    assign c_exp   = (c == CH_EXP_LO) || (c == CH_EXP_UP);
    assign c_radix = (c == radix_reg);

    // Restart the counters on the first character of a string
    assign start_base = (phase_reg == PH_FIRST) ? in_data.base_position : start_reg;
    assign count_base = (phase_reg == PH_FIRST) ? '0 : count_reg;
    assign digit_base = (phase_reg == PH_FIRST) ? 1'b0 : digit_reg;

    // Next phase: white space falls into the integer rule, which falls into
    // the fraction rule, all within the same beat
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_FIRST, PH_WS:
            begin
                if (c_ws)
                    phase_next = PH_WS;
                else if (c_sgn)
                    phase_next = PH_INT;
                else if (c_dig)
                    phase_next = PH_INT;
                else if (c_radix)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_DONE;
            end
            PH_INT:
            begin
                if (c_dig)
                    phase_next = PH_INT;
                else if (c_radix)
                    phase_next = PH_FRAC;
                else if (digit_reg && c_exp && !last)
                    phase_next = PH_EXPS;
                else
                    phase_next = PH_DONE;
            end
            PH_FRAC:
            begin
                if (c_dig)
                    phase_next = PH_FRAC;
                else if (digit_reg && c_exp && !last)
                    phase_next = PH_EXPS;
                else
                    phase_next = PH_DONE;
            end
            PH_EXPS:  phase_next = (c_sgn && !last) ? PH_EXPD1 : PH_DONE;
            PH_EXPD1: phase_next = c_dig ? PH_EXPD : PH_DONE;
            PH_EXPD:  phase_next = c_dig ? PH_EXPD : PH_DONE;
            PH_DONE:  phase_next = PH_DONE;
            default:  phase_next = PH_DONE;
        endcase
        if (last)
            phase_next = PH_FIRST;
    end

    // Counter updates for start position, consumed count and digit flag
    always_comb
    begin
        start_next = start_base;
        count_next = count_base;
        digit_next = digit_base;
        case (phase_reg)
            PH_FIRST, PH_WS:
            begin
                if (c_ws)
                    start_next = start_base + 1'b1;
                else if (c_sgn || c_radix || c_dig)
                    count_next = sat_add(count_base, 2'd1);
                if (!c_ws && !c_sgn && c_dig)
                    digit_next = 1'b1;
            end
            PH_INT, PH_FRAC:
            begin
                if (c_dig || (phase_reg == PH_INT && c_radix))
                    count_next = sat_add(count_base, 2'd1);
                if (c_dig)
                    digit_next = 1'b1;
            end
            PH_EXPD1:
            begin
                if (c_dig)
                    count_next = sat_add(count_base, 2'd3);
            end
            PH_EXPD:
            begin
                if (c_dig)
                    count_next = sat_add(count_base, 2'd1);
            end
            default:
            begin
                count_next = count_base;
            end
        endcase
    end

    // Hold the radix register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_reg <= RADIX_RESET;
        else if (cfg_valid && cfg_ready)
            radix_reg <= cfg_data;
    end

    // Advance scan state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            start_reg <= '0;
            count_reg <= '0;
            digit_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            count_reg <= count_next;
            digit_reg <= digit_next;
        end
    end

    // Load the result register on the last character, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && last)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last)
        begin
            out_data_reg.is_number  <= digit_next;
            out_data_reg.start_pos  <= start_next;
            out_data_reg.scan_count <= count_next;
        end
    end

    `NLS_ASSERT_NEXT(a_last_gives_result, in_fire && last,
        out_valid && phase_reg == PH_FIRST, "last character left no result")
    `NLS_ASSERT_NOW(a_no_overwrite, out_valid_reg && !out_ready, !in_ready,
        "input taken while result is stalled")
    `NLS_ASSERT_NOW(a_number_has_count, out_valid && out_data.is_number,
        out_data.scan_count != '0, "number reported with zero count")

endmodule

### verif/testbench.sv
// ------------------------------------------------------------------------
// Numeric literal scanner testbench
// Streams strings through the scanner and compares each result with a
// scoreboard that tracks the scan phases beat by beat. Covers directed
// corner strings, several radix settings and random idling on both sides.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import nls_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS = 10;

    // Scoreboard: tracks the scanner state and holds the pending results
    class literal_scoreboard;
        logic [CHAR_BITS-1:0] radix;
        scan_phase_t          phase;
        logic [POS_BITS-1:0]  cursor;
        logic [POS_BITS-1:0]  lit_start;
        logic [POS_BITS-1:0]  lit_len;
        logic [POS_BITS-1:0]  mant_digits;
        logic                 any_digit;
        nls_out_t             pending_scans[$];
        int unsigned          mismatches;

        function new();
            radix       = RADIX_RESET;
            phase       = PH_FIRST;
            cursor      = '0;
            lit_start   = '0;
            lit_len     = '0;
            mant_digits = '0;
            any_digit   = 1'b0;
            mismatches  = 0;
        endfunction

        function logic is_space(logic [CHAR_BITS-1:0] c);
            return (c >= 8'd9 && c <= 8'd13) || c == 8'd32;
        endfunction

        function logic is_digit(logic [CHAR_BITS-1:0] c);
            return c >= 8'd48 && c <= 8'd57;
        endfunction

        function logic is_sign(logic [CHAR_BITS-1:0] c);
            return c == CH_PLUS || c == CH_MINUS;
        endfunction

        // Add to a count, clamping at all ones
        function logic [POS_BITS-1:0] bump(logic [POS_BITS-1:0] a, int unsigned n);
            logic [POS_BITS:0] s;
            s = {1'b0, a} + n[POS_BITS:0];
            return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
        endfunction

        function void count_digit();
            lit_len     = bump(lit_len, 1);
            mant_digits = bump(mant_digits, 1);
            any_digit   = 1'b1;
        endfunction

        function int unsigned pending();
            return pending_scans.size();
        endfunction

        // Advance the scan by one accepted character beat
        function void note_char(nls_in_t beat);
            logic                 again;
            logic [CHAR_BITS-1:0] c;
            nls_out_t             res;
            c = beat.char_code;
            if (phase == PH_FIRST) begin
                cursor      = beat.base_position;
                lit_start   = beat.base_position;
                lit_len     = '0;
                mant_digits = '0;
                any_digit   = 1'b0;
                phase       = PH_WS;
            end
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (phase)
                    PH_WS: begin
                        if (is_space(c)) begin
                            lit_start = lit_start + 1'b1;
                        end else if (is_sign(c)) begin
                            lit_len = bump(lit_len, 1);
                            phase   = PH_INT;
                        end else begin
                            phase = PH_INT;
                            again = 1'b1;
                        end
                    end
                    PH_INT: begin
                        if (is_digit(c)) begin
                            count_digit();
                        end else if (c == radix) begin
                            lit_len = bump(lit_len, 1);
                            phase   = PH_FRAC;
                        end else begin
                            phase = PH_FRAC;
                            again = 1'b1;
                        end
                    end
                    PH_FRAC: begin
                        if (is_digit(c))
                            count_digit();
                        else if (any_digit && (c == CH_EXP_LO || c == CH_EXP_UP)
                                 && !beat.last_char)
                            phase = PH_EXPS;
                        else
                            phase = PH_DONE;
                    end
                    PH_EXPS: begin
                        phase = (is_sign(c) && !beat.last_char) ? PH_EXPD1 : PH_DONE;
                    end
                    PH_EXPD1: begin
                        if (is_digit(c)) begin
                            lit_len = bump(lit_len, 3);
                            phase   = PH_EXPD;
                        end else begin
                            phase = PH_DONE;
                        end
                    end
                    PH_EXPD: begin
                        if (is_digit(c))
                            lit_len = bump(lit_len, 1);
                        else
                            phase = PH_DONE;
                    end
                    default: phase = PH_DONE;
                endcase
            end
            cursor = cursor + 1'b1;
            if (beat.last_char) begin
                res.is_number  = any_digit;
                res.start_pos  = lit_start;
                res.scan_count = lit_len;
                pending_scans.push_back(res);
                phase = PH_FIRST;
            end
        endfunction

        // Compare one result beat with the oldest pending scan
        function void check_result(nls_out_t got);
            nls_out_t want;
            if (pending_scans.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: is_number=%0d start_pos=%0d scan_count=%0d",
                             got.is_number, got.start_pos, got.scan_count);
                return;
            end
            want = pending_scans.pop_front();
            if (got.is_number != want.is_number || got.start_pos != want.start_pos
                || got.scan_count != want.scan_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result differs: is_number %0d/%0d start_pos %0d/%0d %s %0d/%0d",
                             want.is_number, got.is_number, want.start_pos,
                             got.start_pos, "scan_count (expected/actual)",
                             want.scan_count, got.scan_count);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CHAR_BITS-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    nls_in_t              in_data;
    logic                 out_valid;
    logic                 out_ready;
    nls_out_t             out_data;

    literal_scoreboard    sb = new();
    logic [7:0]           text[$];
    int unsigned          idle_pct;
    int unsigned          stall_pct;
    int unsigned          quiet_cycles;

    numeric_literal_scanner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Check every result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one character beat, idling first at random, and hold until taken
    task automatic push_char(input nls_in_t beat);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_char(beat);
    endtask

    // Send the buffered string; base position rides on the first beat only
    task automatic send_text(input logic [POS_BITS-1:0] base);
        nls_in_t beat;
        foreach (text[i]) begin
            beat.char_code     = text[i];
            beat.base_position = (i == 0) ? base : POS_BITS'($urandom);
            beat.last_char     = (i == text.size() - 1);
            push_char(beat);
        end
        text.delete();
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_radix(input logic [CHAR_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.radix = value;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    function automatic logic [7:0] any_space();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_sign();
        return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    endfunction

    function automatic logic [7:0] any_exp();
        return $urandom_range(0, 1) ? CH_EXP_LO : CH_EXP_UP;
    endfunction

    // Build a literal from random optional parts and a random tail
    task automatic add_literal();
        int unsigned n;
        n = $urandom_range(0, 3);
        repeat (n) text.push_back(any_space());
        if ($urandom_range(0, 1))
            text.push_back(any_sign());
        n = $urandom_range(0, 4);
        repeat (n) text.push_back(any_digit());
        if ($urandom_range(0, 9) < 6)
            text.push_back(sb.radix);
        n = $urandom_range(0, 4);
        repeat (n) text.push_back(any_digit());
        if ($urandom_range(0, 9) < 4) begin
            text.push_back(any_exp());
            text.push_back(any_sign());
            n = $urandom_range(1, 3);
            repeat (n) text.push_back(any_digit());
        end
        n = $urandom_range(0, 3);
        repeat (n) text.push_back(8'($urandom_range(0, 255)));
        if (text.size() == 0)
            text.push_back(any_digit());
    endtask

    // Build a broken literal or plain noise
    task automatic add_broken();
        int unsigned n;
        text.push_back(any_digit());
        case ($urandom_range(0, 6))
            0: text.push_back(any_exp());
            1: begin
                text.push_back(any_exp());
                text.push_back(any_sign());
            end
            2: begin
                text.push_back(any_exp());
                text.push_back(any_digit());
            end
            3: begin
                text.push_back(any_exp());
                text.push_back(any_sign());
                text.push_back(8'($urandom_range(0, 255)));
            end
            4: begin
                text.delete();
                text.push_back(any_sign());
                text.push_back(sb.radix);
                if ($urandom_range(0, 1))
                    text.push_back(any_exp());
            end
            5: begin
                text.delete();
                n = $urandom_range(1, 6);
                repeat (n) text.push_back(any_space());
            end
            default: begin
                text.delete();
                n = $urandom_range(1, 8);
                repeat (n) text.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    function automatic logic [POS_BITS-1:0] any_base();
        if ($urandom_range(0, 9) == 0)
            return {POS_BITS{1'b1}} - POS_BITS'($urandom_range(0, 7));
        return POS_BITS'($urandom);
    endfunction

    initial
    begin
        int unsigned          sent;
        logic [CHAR_BITS-1:0] radix_plan[8];

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        idle_pct  = 0;
        stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings at the reset radix
        add_str("0");                   send_text(16'h0000);
        add_str(" -1.5e+3x");           send_text(16'hFFFF);
        add_str("\t \r");               send_text(16'hFFFE);
        add_str("+");                   send_text(16'h1234);
        add_str("7.");                  send_text(16'h8000);
        add_str("3e");                  send_text(16'h00FF);
        add_str("5E+");                 send_text(16'h7FFF);
        text.push_back(8'hFF);
        text.push_back(8'h80);          send_text(16'h5555);

        // Radix that collides with a digit, white space, a sign, a high code
        wait_idle();  write_radix(8'd53);   add_str("15.5");  send_text(16'h0010);
        wait_idle();  write_radix(CH_SPACE); add_str("1 5");  send_text(16'h0020);
        wait_idle();  write_radix(CH_MINUS); add_str("-2-5"); send_text(16'h0030);
        wait_idle();  write_radix(8'hFF);
        text.push_back(8'd56);
        text.push_back(8'hFF);
        text.push_back(8'd56);          send_text(16'hAAAA);

        // Run of digits followed by a full exponent
        wait_idle();
        write_radix(RADIX_RESET);
        repeat (40) text.push_back(8'd49);
        add_str("e+55");
        send_text(16'h0100);

        // Random phases with different idling and radix settings
        radix_plan = '{8'd44, 8'h00, 8'hFF, RADIX_RESET, 8'd0, 8'd101, 8'd43, 8'd46};
        radix_plan[4] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_radix(radix_plan[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            sent = 0;
            while (sent < 150) begin
                if ($urandom_range(0, 3) != 0)
                    add_literal();
                else
                    add_broken();
                sent += text.size();
                send_text(any_base());
                if ($urandom_range(0, 29) == 0)
                    wait_idle();
            end
        end

        // Drain and settle, then report
        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
